### hw/rtl/cted_pkg.sv
// Package for the capped transposition edit distance unit: sizes, codes, types and helpers.
package cted_pkg;

    localparam int MAX_LEN   = 32;
    localparam int LEN_W     = $clog2(MAX_LEN + 1);
    localparam int WADDR_W   = $clog2(MAX_LEN);
    localparam int ROW_DEPTH = MAX_LEN + 1;
    localparam int CHAR_W    = 8;

    typedef logic [1:0] cell_t;

    localparam cell_t CELL_CAP = 2'd3;

    typedef enum logic [1:0] {
        REQ_APPEND  = 2'd0,
        REQ_PROCESS = 2'd1,
        REQ_FINISH  = 2'd2
    } req_t;

    typedef enum logic {
        ST_IDLE,
        ST_SWEEP
    } state_t;

    typedef struct packed {
        cell_t older;
        cell_t prev;
    } row_entry_t;

    function automatic cell_t sat3(input logic [LEN_W:0] x);
        cell_t r;
        if (x > {{(LEN_W - 1){1'b0}}, CELL_CAP})
        begin
            r = CELL_CAP;
        end
        else
        begin
            r = x[1:0];
        end
        return r;
    endfunction

    function automatic logic [2:0] min3(input logic [2:0] a, input logic [2:0] b);
        return (a < b) ? a : b;
    endfunction

endpackage

### hw/rtl/cted_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module cted_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/capped_transposition_edit_distance_unit.sv
// Top level of the capped transposition edit distance unit.
//
//  channel | signals                          | content
//  s_      | s_tvalid s_tready s_tdata s_tuser | char_code in tdata, req_type in tuser
//  m_      | m_tvalid m_tready m_tdata         | distance, overflow in tdata
//
//  A finish result waits in an output register while further appends are taken.
//  A first-word character sweeps the row memory one column a cycle, over columns
//  0 to the second word length, set by the single read and write port of that memory.
//  Reset clears all control state at once; no clearing pass is needed.
//  A finish is held off while an earlier result is still not taken.
module capped_transposition_edit_distance_unit
    import cted_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_code
    input  logic [1:0] s_tuser,   // [1:0] req_type
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [1:0] distance, [2] overflow, [7:3] zero
);

    state_t             state_reg, state_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    cell_t              rows_done_reg, rows_done_next;
    logic               dropped_reg, dropped_next;
    logic [CHAR_W-1:0]  pchar_reg, pchar_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    cell_t              final_reg, final_next;
    logic [LEN_W-1:0]   rd_idx_reg, rd_idx_next;
    logic               iss_done_reg, iss_done_next;
    logic               pend_reg, pend_next;
    logic [LEN_W-1:0]   cell_idx_reg, cell_idx_next;
    cell_t              prev_jm1_reg, prev_jm1_next;
    cell_t              cur_jm1_reg, cur_jm1_next;
    cell_t              older_jm1_reg, older_jm1_next;
    cell_t              older_jm2_reg, older_jm2_next;
    logic [CHAR_W-1:0]  word_jm1_reg, word_jm1_next;
    logic [CHAR_W-1:0]  word_jm2_reg, word_jm2_next;
    logic               out_valid_reg, out_valid_next;
    cell_t              out_dist_reg, out_dist_next;
    logic               out_ovf_reg, out_ovf_next;

    logic               s_fire;
    logic               issue;
    logic               last_cell;

    logic               word_we;
    logic [WADDR_W-1:0] word_waddr;
    logic [WADDR_W-1:0] word_raddr;
    logic [CHAR_W-1:0]  word_rdata;
    logic               row_we;
    row_entry_t         row_wdata;
    row_entry_t         row_rdata;

    cell_t              prev_j;
    cell_t              cur_j;
    logic [2:0]         best;
    logic               trans_hit;

    cted_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LEN)) u_word_ram (
        .clk   (clk),
        .we    (word_we),
        .waddr (word_waddr),
        .wdata (s_tdata),
        .raddr (word_raddr),
        .rdata (word_rdata)
    );

    cted_ram #(.WIDTH($bits(row_entry_t)), .DEPTH(ROW_DEPTH)) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (cell_idx_reg),
        .wdata (row_wdata),
        .raddr (rd_idx_reg),
        .rdata (row_rdata)
    );

    assign s_fire    = s_tvalid && s_tready;
    assign issue     = (state_reg == ST_SWEEP) && !iss_done_reg;
    assign last_cell = pend_reg && (cell_idx_reg == len_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire && (s_tuser == REQ_PROCESS))
                begin
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                if (last_cell)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready   = 1'b0;
        row_we     = 1'b0;
        word_we    = 1'b0;
        word_waddr = len_reg[WADDR_W-1:0];
        word_raddr = '0;
        if (rd_idx_reg < len_reg)
        begin
            word_raddr = rd_idx_reg[WADDR_W-1:0];
        end
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = !out_valid_reg || m_tready || (s_tuser != REQ_FINISH);
                word_we  = s_fire && (s_tuser == REQ_APPEND) && (rows_done_reg == 2'd0)
                           && (len_reg < LEN_W'(MAX_LEN));
            end
            ST_SWEEP:
            begin
                row_we = pend_reg;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // one cell of the row
    always_comb
    begin
        prev_j = (rows_done_reg == 2'd0) ? sat3({1'b0, cell_idx_reg}) : row_rdata.prev;
        best = min3({1'b0, prev_j} + 3'd1, {1'b0, cur_jm1_reg} + 3'd1);
        best = min3(best, {1'b0, prev_jm1_reg} + ((char_reg != word_jm1_reg) ? 3'd1 : 3'd0));
        trans_hit = (rows_done_reg != 2'd0) && (cell_idx_reg > LEN_W'(1))
                    && (char_reg == word_jm2_reg) && (pchar_reg == word_jm1_reg);
        if (trans_hit)
        begin
            best = min3(best, {1'b0, older_jm2_reg} + 3'd1);
        end
        if (cell_idx_reg == '0)
        begin
            cur_j = sat3({{(LEN_W - 1){1'b0}}, rows_done_reg} + {{LEN_W{1'b0}}, 1'b1});
        end
        else
        begin
            cur_j = sat3({{(LEN_W - 2){1'b0}}, best});
        end
        row_wdata.older = prev_j;
        row_wdata.prev  = cur_j;
    end

    // datapath next values
    always_comb
    begin
        len_next       = len_reg;
        rows_done_next = rows_done_reg;
        dropped_next   = dropped_reg;
        pchar_next     = pchar_reg;
        char_next      = char_reg;
        final_next     = final_reg;
        rd_idx_next    = rd_idx_reg;
        iss_done_next  = iss_done_reg;
        pend_next      = issue;
        cell_idx_next  = rd_idx_reg;
        prev_jm1_next  = prev_jm1_reg;
        cur_jm1_next   = cur_jm1_reg;
        older_jm1_next = older_jm1_reg;
        older_jm2_next = older_jm2_reg;
        word_jm1_next  = word_jm1_reg;
        word_jm2_next  = word_jm2_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_dist_next  = out_dist_reg;
        out_ovf_next   = out_ovf_reg;

        if (s_fire)
        begin
            case (s_tuser)
                REQ_APPEND:
                begin
                    if (rows_done_reg == 2'd0)
                    begin
                        if (len_reg < LEN_W'(MAX_LEN))
                        begin
                            len_next = len_reg + LEN_W'(1);
                        end
                        else
                        begin
                            dropped_next = 1'b1;
                        end
                    end
                end
                REQ_PROCESS:
                begin
                    char_next     = s_tdata;
                    rd_idx_next   = '0;
                    iss_done_next = 1'b0;
                end
                REQ_FINISH:
                begin
                    out_valid_next = 1'b1;
                    out_dist_next  = (rows_done_reg == 2'd0) ? sat3({1'b0, len_reg}) : final_reg;
                    out_ovf_next   = dropped_reg;
                    len_next       = '0;
                    rows_done_next = 2'd0;
                    dropped_next   = 1'b0;
                    pchar_next     = '0;
                end
                default:
                begin
                    out_valid_next = out_valid_reg && !m_tready;
                end
            endcase
        end

        if (issue)
        begin
            rd_idx_next   = rd_idx_reg + LEN_W'(1);
            iss_done_next = (rd_idx_reg == len_reg);
        end

        if (pend_reg)
        begin
            prev_jm1_next  = prev_j;
            cur_jm1_next   = cur_j;
            older_jm1_next = row_rdata.older;
            older_jm2_next = older_jm1_reg;
            word_jm1_next  = word_rdata;
            word_jm2_next  = word_jm1_reg;
        end

        if (last_cell)
        begin
            final_next     = cur_j;
            pchar_next     = char_reg;
            rows_done_next = (rows_done_reg == CELL_CAP) ? CELL_CAP : rows_done_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            rows_done_reg <= '0;
            dropped_reg   <= 1'b0;
            pchar_reg     <= '0;
            final_reg     <= '0;
            iss_done_reg  <= 1'b1;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            rows_done_reg <= rows_done_next;
            dropped_reg   <= dropped_next;
            pchar_reg     <= pchar_next;
            final_reg     <= final_next;
            iss_done_reg  <= iss_done_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg      <= char_next;
        rd_idx_reg    <= rd_idx_next;
        cell_idx_reg  <= cell_idx_next;
        prev_jm1_reg  <= prev_jm1_next;
        cur_jm1_reg   <= cur_jm1_next;
        older_jm1_reg <= older_jm1_next;
        older_jm2_reg <= older_jm2_next;
        word_jm1_reg  <= word_jm1_next;
        word_jm2_reg  <= word_jm2_next;
        out_dist_reg  <= out_dist_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_ovf_reg, out_dist_reg};

`ifndef SYNTHESIS
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(MAX_LEN))
        else $error("word length beyond store");

    a_sweep_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> !s_tready)
        else $error("transaction taken during row sweep");

    a_len_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        ((rows_done_reg != 2'd0) && !(s_fire && (s_tuser == REQ_FINISH)))
        |=> $stable(len_reg))
        else $error("second word changed after first-word characters");

    a_finish_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && (s_tuser == REQ_FINISH)) |=> (m_tvalid && (rows_done_reg == 2'd0)))
        else $error("finish did not produce a result or clear");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !row_we)
        else $error("row write outside sweep");
`endif

endmodule
